// ----- rtl/spr_pkg.sv -----
package spr_pkg;

   localparam int BYTE_W = 8;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int LEN_W = 4;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef enum logic [1:0] {
      CSR_PATTERN_BYTES,
      CSR_PATTERN_LENGTH,
      CSR_REPLACEMENT_BYTES,
      CSR_REPLACEMENT_LENGTH
   } csr_index_type;

endpackage

// ----- rtl/spr_scan.sv -----
module spr_scan
   import spr_pkg::*;
#(
   parameter int PATTERN_MAX = 8,
   parameter int REPLACEMENT_MAX = 8,
   localparam int KW = $clog2(PATTERN_MAX),
   localparam int RUN_MAX = (PATTERN_MAX > REPLACEMENT_MAX) ? PATTERN_MAX : REPLACEMENT_MAX,
   localparam int LW = $clog2(RUN_MAX + 1)
) (
   input  logic [CSR_DATA_W-1:0] pattern_bytes,
   input  logic [LEN_W-1:0]      pattern_length,
   input  logic [CSR_DATA_W-1:0] replacement_bytes,
   input  logic [LEN_W-1:0]      replacement_length,
   input  logic [KW-1:0]         pending_count,
   input  byte_type              data_byte,
   input  logic                  end_of_stream,
   output byte_type              run_bytes [RUN_MAX],
   output logic [LW-1:0]         run_len,
   output logic [KW-1:0]         next_count
);

   localparam int CW = $clog2(PATTERN_MAX + 1);
   localparam int RCW = $clog2(REPLACEMENT_MAX + 1);

   logic [CW-1:0]  plen_eff;
   logic [KW-1:0]  plen_m1;
   logic [KW-1:0]  k;
   logic [RCW-1:0] rlen_eff;
   byte_type       buf_bytes [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] cand;
   logic [CW-1:0]  n_count;
   logic [CW-1:0]  first_start;
   logic           match;

   always_comb begin
      if (pattern_length == '0) begin
         plen_eff = CW'(1);
      end else if (pattern_length > LEN_W'(PATTERN_MAX)) begin
         plen_eff = CW'(PATTERN_MAX);
      end else begin
         plen_eff = pattern_length[CW-1:0];
      end
      plen_m1 = KW'(plen_eff - CW'(1));
      k = (pending_count > plen_m1) ? plen_m1 : pending_count;
      if (replacement_length > LEN_W'(REPLACEMENT_MAX)) begin
         rlen_eff = RCW'(REPLACEMENT_MAX);
      end else begin
         rlen_eff = replacement_length[RCW-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         buf_bytes[i] = (KW'(i) < k) ? pattern_bytes[BYTE_W*i +: BYTE_W] : data_byte;
      end
   end

   // a start is a candidate when the tail of the buffer from it is a pattern prefix
   always_comb begin
      for (int s = 0; s < PATTERN_MAX; s++) begin
         cand[s] = (KW'(s) <= k);
         for (int j = 0; j < PATTERN_MAX; j++) begin
            if (s + j < PATTERN_MAX) begin
               if (KW'(s + j) <= k &&
                   buf_bytes[s + j] != pattern_bytes[BYTE_W*j +: BYTE_W]) begin
                  cand[s] = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      n_count = CW'(k) + CW'(1);
      first_start = n_count;
      for (int s = PATTERN_MAX - 1; s >= 0; s--) begin
         if (cand[s]) begin
            first_start = CW'(s);
         end
      end
      match = cand[0] && (k == plen_m1);
      if (match) begin
         run_len = LW'(rlen_eff);
      end else if (end_of_stream) begin
         run_len = LW'(n_count);
      end else begin
         run_len = LW'(first_start);
      end
      next_count = (match || end_of_stream) ? '0 : KW'(n_count - first_start);
   end

   always_comb begin
      for (int i = 0; i < RUN_MAX; i++) begin
         run_bytes[i] = '0;
         if (match) begin
            if (i < REPLACEMENT_MAX) begin
               run_bytes[i] = replacement_bytes[BYTE_W*i +: BYTE_W];
            end
         end else begin
            if (i < PATTERN_MAX) begin
               run_bytes[i] = buf_bytes[i % PATTERN_MAX];
            end
         end
      end
   end

endmodule

// ----- rtl/stream_pattern_replace_top.sv -----
// Stream find-and-replace for a byte stream.
// req_*: one input item per handshake, the byte in req_tdata, req_tlast marking
// the final byte of the stream. rsp_*: one output byte per handshake; rsp_tlast
// marks the last byte caused by an input item, rsp_tuser marks that last byte
// when the input item was the final one of the stream.
// csr_*: write the pattern (up to eight bytes), its length, the replacement
// (zero to eight bytes) and its length at byte addresses 0, 8, 16 and 24.
// An accepted item is matched in the same cycle against the pending prefix
// count; its output bytes (0 to 8) land in a run register and leave one per
// cycle while the receiver is ready, the first in the cycle after acceptance.
// Unstalled, an item causing at most one byte sustains one item per cycle; a
// longer run holds the input, the next item being taken with its last byte.
// Reset clears the pending count, drops any run in flight and sets the
// pattern length to 1 with the other CSR registers zero.
// While the receiver stalls, the current byte holds and no new item is taken.
module stream_pattern_replace_top
   import spr_pkg::*;
#(
   parameter int PATTERN_MAX = 8,
   parameter int REPLACEMENT_MAX = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,    // data_byte
   input  logic                  req_tlast,    // end_of_stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,    // out_byte
   output logic                  rsp_tlast,    // run_last
   output logic                  rsp_tuser,    // stream_done
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int KW = $clog2(PATTERN_MAX);
   localparam int RUN_MAX = (PATTERN_MAX > REPLACEMENT_MAX) ? PATTERN_MAX : REPLACEMENT_MAX;
   localparam int LW = $clog2(RUN_MAX + 1);
   localparam int IW = $clog2(RUN_MAX);

   logic [CSR_DATA_W-1:0] pattern_bytes_ff, pattern_bytes_in;
   logic [LEN_W-1:0]      pattern_length_ff, pattern_length_in;
   logic [CSR_DATA_W-1:0] replacement_bytes_ff, replacement_bytes_in;
   logic [LEN_W-1:0]      replacement_length_ff, replacement_length_in;

   logic [KW-1:0] pending_ff, pending_in;
   byte_type      run_bytes_ff [RUN_MAX];
   byte_type      run_bytes_in [RUN_MAX];
   logic [LW-1:0] run_len_ff, run_len_in;
   logic [LW-1:0] run_pos_ff, run_pos_in;
   logic          run_eos_ff, run_eos_in;

   byte_type      scan_bytes [RUN_MAX];
   logic [LW-1:0] scan_len;
   logic [KW-1:0] scan_next;
   logic          csr_write;
   csr_index_type csr_index;
   logic          req_fire;
   logic          rsp_fire;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = csr_index_type'(csr_paddr[CSR_ADDR_W-1:3]);

   always_comb begin
      pattern_bytes_in = pattern_bytes_ff;
      pattern_length_in = pattern_length_ff;
      replacement_bytes_in = replacement_bytes_ff;
      replacement_length_in = replacement_length_ff;
      csr_prdata = '0;
      unique case (csr_index)
         CSR_PATTERN_BYTES: begin
            csr_prdata = pattern_bytes_ff;
            if (csr_write) pattern_bytes_in = csr_pwdata;
         end
         CSR_PATTERN_LENGTH: begin
            csr_prdata = CSR_DATA_W'(pattern_length_ff);
            if (csr_write) pattern_length_in = csr_pwdata[LEN_W-1:0];
         end
         CSR_REPLACEMENT_BYTES: begin
            csr_prdata = replacement_bytes_ff;
            if (csr_write) replacement_bytes_in = csr_pwdata;
         end
         CSR_REPLACEMENT_LENGTH: begin
            csr_prdata = CSR_DATA_W'(replacement_length_ff);
            if (csr_write) replacement_length_in = csr_pwdata[LEN_W-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff <= '0;
         pattern_length_ff <= LEN_W'(1);
         replacement_bytes_ff <= '0;
         replacement_length_ff <= '0;
      end else begin
         pattern_bytes_ff <= pattern_bytes_in;
         pattern_length_ff <= pattern_length_in;
         replacement_bytes_ff <= replacement_bytes_in;
         replacement_length_ff <= replacement_length_in;
      end
   end

   spr_scan #(
      .PATTERN_MAX     (PATTERN_MAX),
      .REPLACEMENT_MAX (REPLACEMENT_MAX)
   ) u_scan (
      .pattern_bytes      (pattern_bytes_ff),
      .pattern_length     (pattern_length_ff),
      .replacement_bytes  (replacement_bytes_ff),
      .replacement_length (replacement_length_ff),
      .pending_count      (pending_ff),
      .data_byte          (req_tdata),
      .end_of_stream      (req_tlast),
      .run_bytes          (scan_bytes),
      .run_len            (scan_len),
      .next_count         (scan_next)
   );

   assign rsp_tvalid = (run_pos_ff != run_len_ff);
   assign rsp_tlast = (run_pos_ff == run_len_ff - LW'(1));
   assign rsp_tuser = rsp_tlast && run_eos_ff;
   assign rsp_tdata = run_bytes_ff[run_pos_ff[IW-1:0]];
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign req_tready = !rsp_tvalid || (rsp_tready && rsp_tlast);
   assign req_fire = req_tvalid && req_tready;

   always_comb begin
      pending_in = pending_ff;
      run_bytes_in = run_bytes_ff;
      run_len_in = run_len_ff;
      run_pos_in = run_pos_ff;
      run_eos_in = run_eos_ff;
      if (req_fire) begin
         pending_in = scan_next;
         run_bytes_in = scan_bytes;
         run_len_in = scan_len;
         run_pos_in = '0;
         run_eos_in = req_tlast;
      end else if (rsp_fire) begin
         run_pos_in = run_pos_ff + LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         run_len_ff <= '0;
         run_pos_ff <= '0;
         run_eos_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         run_len_ff <= run_len_in;
         run_pos_ff <= run_pos_in;
         run_eos_ff <= run_eos_in;
      end
   end

   always_ff @(posedge clock) begin
      run_bytes_ff <= run_bytes_in;
   end

`ifndef SYNTH
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("run ended before its last byte");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> pending_ff == '0)
      else $error("pending count not cleared after final item");

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("stream_done away from the last byte of a run");

   a_take_on_drain: assert property (@(posedge clock) disable iff (reset)
      req_tready && rsp_tvalid |-> rsp_tready && rsp_tlast)
      else $error("item taken while a run is still pending");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      run_pos_ff <= run_len_ff && run_len_ff <= LW'(RUN_MAX))
      else $error("run position out of range");
`endif

endmodule
